### rtl/fmbs_pkg.sv
package fmbs_pkg;

  localparam int TEXT_DEPTH = 16384;
  localparam int MAX_BLOCKS = 256;
  localparam int ALPHABET   = 256;

  localparam int BW   = 15;                         // bound / count width
  localparam int SW   = 8;                          // symbol width
  localparam int AW   = 16;                         // load address width
  localparam int NBW  = 9;                          // block_count width
  localparam int BKW  = $clog2(MAX_BLOCKS);         // stored block index width
  localparam int TAW  = $clog2(TEXT_DEPTH);         // bwt address width
  localparam int CKAW = BKW + SW;                   // checkpoint address width
  localparam int DCW  = $clog2(BW + 1);             // divider step counter width

  localparam logic [BW-1:0]  BOUND_MAX = {BW{1'b1}};
  localparam logic [BW-1:0]  N_MAX     = BW'(TEXT_DEPTH);
  localparam logic [NBW-1:0] NB_MAX    = NBW'(MAX_BLOCKS);

  typedef enum logic [1:0] {
    ACT_LOAD_START = 2'd0,
    ACT_LOAD_CKPT  = 2'd1,
    ACT_LOAD_BWT   = 2'd2,
    ACT_PATTERN    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_TEXT_LENGTH = 2'd0,
    REG_SAMPLE_STEP = 2'd1,
    REG_BLOCK_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_CHK  = 10'b0000000010,
    S_PREP = 10'b0000000100,
    S_DIV  = 10'b0000001000,
    S_ADJ  = 10'b0000010000,
    S_MUL  = 10'b0000100000,
    S_OFF  = 10'b0001000000,
    S_SCAN = 10'b0010000000,
    S_SUM  = 10'b0100000000,
    S_EMIT = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic accept;   // input port ready
    logic prep;     // pick bound, clamp, load divider
    logic div;      // one divider step
    logic adj;      // clamp block index
    logic mul;      // block start = blk * step
    logic off;      // scan length, table reads
    logic scan;     // one bwt byte per cycle
    logic sum;      // form new bound
    logic sel;      // 0 low bound, 1 high bound
    logic emit;     // load output register
  } cmd_t;

  typedef struct packed {
    logic pattern;  // accepted item is a pattern byte
    logic dead;
    logic last;
    logic div_last;
    logic scan_done;
    logic out_full;
  } status_t;

endpackage

### rtl/fmbs_if.sv
interface fmbs_in_if (input logic clk);
  import fmbs_pkg::*;
  logic          valid;
  logic          ready;
  logic [1:0]    action;
  logic [AW-1:0] address;
  logic [BW-1:0] load_value;
  logic [SW-1:0] symbol;
  logic          first_byte;
  logic          last_byte;
  modport source (input clk, ready, output valid, action, address, load_value, symbol,
                  first_byte, last_byte);
  modport sink (input clk, valid, action, address, load_value, symbol, first_byte,
                last_byte, output ready);
endinterface

interface fmbs_out_if (input logic clk);
  import fmbs_pkg::*;
  logic          valid;
  logic          ready;
  logic [BW-1:0] interval_low;
  logic [BW-1:0] interval_high;
  logic [BW-1:0] match_count;
  modport source (input clk, ready, output valid, interval_low, interval_high, match_count);
  modport sink (input clk, valid, interval_low, interval_high, match_count, output ready);
endinterface

### rtl/fmbs_ctrl.sv
module fmbs_ctrl import fmbs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_fire,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.sel   = sel_r;
    case (state_r)
      S_IDLE: begin
        cmd.accept = 1'b1;
        if (in_fire && st.pattern) state_nxt = S_CHK;
      end
      S_CHK: begin
        sel_nxt   = 1'b0;
        state_nxt = st.dead ? S_EMIT : S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (st.div_last) state_nxt = S_ADJ;
      end
      S_ADJ: begin
        cmd.adj   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_OFF;
      end
      S_OFF: begin
        cmd.off   = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_PREP;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!st.last) begin
          state_nxt = S_IDLE;
        end else if (!st.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### rtl/fmbs_dp.sv
module fmbs_dp import fmbs_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  cmd_t           cmd,
  output status_t        st,
  input  logic           in_fire,
  input  logic [1:0]     in_action,
  input  logic [AW-1:0]  in_address,
  input  logic [BW-1:0]  in_load_value,
  input  logic [SW-1:0]  in_symbol,
  input  logic           in_first_byte,
  input  logic           in_last_byte,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [BW-1:0]  cfg_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [BW-1:0]  out_low,
  output logic [BW-1:0]  out_high,
  output logic [BW-1:0]  out_count
);

  logic [BW-1:0] start_mem [ALPHABET];
  logic [BW-1:0] ckpt_mem  [MAX_BLOCKS*ALPHABET];
  logic [SW-1:0] bwt_mem   [TEXT_DEPTH];

  logic [BW-1:0]  text_length_r, sample_step_r;
  logic [NBW-1:0] block_count_r;
  logic [BW-1:0]  n_eff, step_eff;
  logic [NBW-1:0] nb_eff;

  logic [SW-1:0]  sym_r;
  logic           last_r, dead_r;
  logic [BW-1:0]  low_r, high_r, pos_r;
  logic           zero_r, ovf_r;
  logic [BW-1:0]  quot_r, rem_r;
  logic [DCW-1:0] div_cnt_r;
  logic [BKW-1:0] blk_r;
  logic [BW-1:0]  first_r, k_r, off_cnt_r, extra_r;
  logic           rd_vld_r;
  logic [BW-1:0]  start_q, ckpt_q;
  logic [SW-1:0]  bwt_q;
  logic           out_valid_r;
  logic [BW-1:0]  out_low_r, out_high_r, out_count_r;

  logic [BW-1:0]  bound, off_nxt;
  logic [BW:0]    div_t;
  logic           div_ge;
  logic [BW:0]    occ;
  logic [BW+1:0]  v;
  logic [BW-1:0]  bound_nxt;
  logic [2*BW-1:0] prod;

  assign n_eff    = (text_length_r > N_MAX) ? N_MAX : text_length_r;
  assign step_eff = (sample_step_r == '0) ? BW'(1) : sample_step_r;
  assign nb_eff   = (block_count_r == '0) ? NBW'(1) :
                    (block_count_r > NB_MAX) ? NB_MAX : block_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_length_r <= N_MAX;
      sample_step_r <= BW'(64);
      block_count_r <= NB_MAX;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TEXT_LENGTH: text_length_r <= cfg_data;
        REG_SAMPLE_STEP: sample_step_r <= cfg_data;
        REG_BLOCK_COUNT: block_count_r <= cfg_data[NBW-1:0];
        default: ;
      endcase
    end
  end

  // store writes
  always_ff @(posedge clk) begin
    if (in_fire && in_action == ACT_LOAD_START && in_address < AW'(ALPHABET))
      start_mem[in_address[SW-1:0]] <= in_load_value;
    if (in_fire && in_action == ACT_LOAD_CKPT &&
        {1'b0, in_address} < (AW+1)'(MAX_BLOCKS*ALPHABET))
      ckpt_mem[in_address[CKAW-1:0]] <= in_load_value;
    if (in_fire && in_action == ACT_LOAD_BWT && in_address < AW'(TEXT_DEPTH))
      bwt_mem[in_address[TAW-1:0]] <= in_symbol;
  end

  // store reads, registered
  always_ff @(posedge clk) begin
    if (cmd.off) begin
      start_q <= start_mem[sym_r];
      ckpt_q  <= ckpt_mem[{blk_r, sym_r}];
    end
    bwt_q <= bwt_mem[k_r[TAW-1:0]];
  end

  assign bound   = cmd.sel ? high_r : low_r;
  assign div_t   = {rem_r, quot_r[BW-1]};
  assign div_ge  = div_t >= {1'b0, step_eff};
  assign prod    = blk_r * step_eff;
  assign off_nxt = ovf_r ? (pos_r - first_r) : rem_r;
  assign occ     = zero_r ? '0 : ({1'b0, ckpt_q} + {1'b0, extra_r});
  assign v       = {2'b0, start_q} + {1'b0, occ};
  assign bound_nxt = (v > {2'b0, BOUND_MAX}) ? BOUND_MAX : v[BW-1:0];

  always_ff @(posedge clk) begin
    if (in_fire && in_action == ACT_PATTERN) begin
      sym_r  <= in_symbol;
      last_r <= in_last_byte;
    end
    if (cmd.prep) begin
      pos_r     <= (bound > n_eff) ? n_eff : bound;
      zero_r    <= (bound == '0);
      quot_r    <= (bound > n_eff) ? n_eff : bound;
      rem_r     <= '0;
      div_cnt_r <= DCW'(BW);
    end
    if (cmd.div) begin
      rem_r     <= div_ge ? BW'(div_t - {1'b0, step_eff}) : div_t[BW-1:0];
      quot_r    <= {quot_r[BW-2:0], div_ge};
      div_cnt_r <= div_cnt_r - DCW'(1);
    end
    if (cmd.adj) begin
      // block index past the stored blocks falls back to the last block
      ovf_r <= ({1'b0, quot_r} >= (BW+1)'(nb_eff));
      blk_r <= ({1'b0, quot_r} >= (BW+1)'(nb_eff)) ? BKW'(nb_eff - NBW'(1))
                                                  : quot_r[BKW-1:0];
    end
    if (cmd.mul) first_r <= prod[BW-1:0];
    if (cmd.off) begin
      k_r       <= first_r;
      off_cnt_r <= off_nxt;
      extra_r   <= '0;
    end
    if (cmd.scan) begin
      if (off_cnt_r != '0) begin
        k_r       <= k_r + BW'(1);
        off_cnt_r <= off_cnt_r - BW'(1);
      end
      if (rd_vld_r && bwt_q == sym_r) extra_r <= extra_r + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r    <= '0;
      high_r   <= '0;
      dead_r   <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan && (off_cnt_r != '0);
      if (in_fire && in_action == ACT_PATTERN && in_first_byte) begin
        low_r  <= '0;
        high_r <= n_eff;
        dead_r <= 1'b0;
      end
      if (cmd.sum) begin
        if (!cmd.sel) begin
          low_r <= bound_nxt;
        end else begin
          high_r <= bound_nxt;
          if (low_r >= bound_nxt) dead_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_low_r   <= dead_r ? '0 : low_r;
      out_high_r  <= dead_r ? '0 : high_r;
      out_count_r <= dead_r ? '0 : (high_r - low_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_low   = out_low_r;
  assign out_high  = out_high_r;
  assign out_count = out_count_r;

  assign st.pattern   = (in_action == ACT_PATTERN);
  assign st.dead      = dead_r;
  assign st.last      = last_r;
  assign st.div_last  = (div_cnt_r == DCW'(1));
  assign st.scan_done = (off_cnt_r == '0) && !rd_vld_r;
  assign st.out_full  = out_valid_r && !out_ready;

endmodule

### rtl/fm_index_backward_search.sv
// FM-index backward search. Load items (start table, checkpoint counts, BWT
// bytes) are written as they are accepted. A pattern byte computes both
// interval bounds in turn; each bound runs a 15-step restoring divider for
// pos / sample_step, block clamp, block-start multiply, table reads, then a
// scan of off BWT bytes (off < sample_step, or longer when the last block is
// used) from the block start at one byte per cycle, then a drain of the read
// pipeline. A byte arriving on an empty interval goes from the check straight
// to emit. The result register lets the block take the next item while a
// result waits; it stalls in the emit state only when a new result finds the
// previous one still waiting. Store contents are undefined until loaded.
module fm_index_backward_search import fmbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  fmbs_in_if.sink    in_ch,
  fmbs_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [BW-1:0] cfg_data
);

  cmd_t    cmd;
  status_t st;
  logic    in_fire;

  assign in_ch.ready = cmd.accept;
  assign in_fire     = in_ch.valid && cmd.accept;

  fmbs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .st      (st),
    .cmd     (cmd)
  );

  fmbs_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_fire       (in_fire),
    .in_action     (in_ch.action),
    .in_address    (in_ch.address),
    .in_load_value (in_ch.load_value),
    .in_symbol     (in_ch.symbol),
    .in_first_byte (in_ch.first_byte),
    .in_last_byte  (in_ch.last_byte),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_low       (out_ch.interval_low),
    .out_high      (out_ch.interval_high),
    .out_count     (out_ch.match_count)
  );

endmodule

### rtl/fmbs_checker.sv
module fmbs_checker import fmbs_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input logic [BW-1:0] out_low,
  input logic [BW-1:0] out_high,
  input logic [BW-1:0] out_count
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_low) && $stable(out_high))
    else $error("result item changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count == BW'(out_high - out_low))
    else $error("match_count mismatch");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count == '0 |-> out_low == '0 && out_high == '0)
    else $error("empty interval not reported as zeros");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count != '0 |-> out_low < out_high)
    else $error("live interval not ordered");

endmodule

bind fm_index_backward_search fmbs_checker u_fmbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_low   (out_ch.interval_low),
  .out_high  (out_ch.interval_high),
  .out_count (out_ch.match_count)
);
